// ===== rtl/ghrp_pkg.sv =====
// Types and constants shared by the gamepad report packer files.
`default_nettype none
package ghrp_pkg;

  // One gamepad sample.
  typedef struct packed {
    logic signed [7:0] axis_x;
    logic signed [7:0] axis_y;
    logic signed [7:0] axis_z;
    logic signed [7:0] axis_rz;
    logic signed [7:0] trigger_left;
    logic signed [7:0] trigger_right;
    logic [7:0]        hat_code;
    logic [9:0]        button_bits;
    logic              touch_active;
    logic [15:0]       touch_x;
    logic [15:0]       touch_y;
    logic              touch_click;
  } sample_t;

  // One report byte.
  typedef struct packed {
    logic [5:0] byte_index;
    logic [7:0] report_byte;
    logic       last_byte;
  } out_t;

  // Report bytes that depend on the sample or the state; all others are constant.
  typedef struct packed {
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  stick_z;
    logic [7:0]  stick_rz;
    logic [7:0]  hat_btn;
    logic [7:0]  btn_mid;
    logic [7:0]  frame_btn;
    logic [7:0]  trig_l;
    logic [7:0]  trig_r;
    logic [15:0] rtime;
    logic [7:0]  ttime;
    logic [7:0]  pt_id;
    logic [7:0]  pt_b1;
    logic [7:0]  pt_b2;
    logic [7:0]  pt_b3;
  } rep_t;

  // Running state carried from report to report.
  typedef struct packed {
    logic [5:0]  frame;
    logic [15:0] rtime;
    logic [7:0]  ttime;
    logic [6:0]  cid;
    logic        was_touching;
  } state_t;

  localparam int unsigned ReportLen = 63;
  localparam logic [5:0]  LastIndex = 6'(ReportLen - 1);
  localparam logic [15:0] TimeStep  = 16'd188;
  localparam logic [7:0]  FillerByte = 8'h1b;
  localparam logic [7:0]  PointOff   = 8'h80;
  localparam int unsigned TouchBase = 32;

  // Byte positions within the report.
  localparam logic [5:0] IdxStickX   = 6'd0;
  localparam logic [5:0] IdxStickY   = 6'd1;
  localparam logic [5:0] IdxStickZ   = 6'd2;
  localparam logic [5:0] IdxStickRz  = 6'd3;
  localparam logic [5:0] IdxHatBtn   = 6'd4;
  localparam logic [5:0] IdxBtnMid   = 6'd5;
  localparam logic [5:0] IdxFrameBtn = 6'd6;
  localparam logic [5:0] IdxTrigL    = 6'd7;
  localparam logic [5:0] IdxTrigR    = 6'd8;
  localparam logic [5:0] IdxTimeLo   = 6'd9;
  localparam logic [5:0] IdxTimeHi   = 6'd10;
  localparam logic [5:0] IdxFillA    = 6'd11;
  localparam logic [5:0] IdxFillB    = 6'd29;
  localparam logic [5:0] IdxPktCount = 6'(TouchBase);
  localparam logic [5:0] IdxTtime    = 6'(TouchBase + 1);
  localparam logic [5:0] IdxPtId     = 6'(TouchBase + 2);
  localparam logic [5:0] IdxPtB1     = 6'(TouchBase + 3);
  localparam logic [5:0] IdxPtB2     = 6'(TouchBase + 4);
  localparam logic [5:0] IdxPtB3     = 6'(TouchBase + 5);
  localparam logic [5:0] IdxPt2Id    = 6'(TouchBase + 6);

  // Hat code to report nibble; codes outside the table read as centered.
  function automatic logic [3:0] hat_nibble(input logic [7:0] code);
    logic [3:0] n;
    case (code)
      8'd1:    n = 4'd0;
      8'd2:    n = 4'd1;
      8'd3:    n = 4'd2;
      8'd4:    n = 4'd3;
      8'd5:    n = 4'd4;
      8'd6:    n = 4'd5;
      8'd7:    n = 4'd6;
      8'd8:    n = 4'd7;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ghrp_if.sv =====
// Valid/ready channel interfaces for samples and report bytes.
`default_nettype none
interface ghrp_sample_if;
  logic              valid;
  logic              ready;
  ghrp_pkg::sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ghrp_byte_if;
  logic           valid;
  logic           ready;
  ghrp_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ghrp_build.sv =====
// Combinational builder of the variable report bytes and the next running state.
`default_nettype none
module ghrp_build #(
  parameter int unsigned PAD_WIDTH  = 1920,
  parameter int unsigned PAD_HEIGHT = 943
) (
  input  ghrp_pkg::sample_t smp_i,
  input  ghrp_pkg::state_t  st_i,
  output ghrp_pkg::rep_t    rep_o,
  output ghrp_pkg::state_t  st_o
);

  localparam logic [15:0] PadW    = 16'(PAD_WIDTH);
  localparam logic [15:0] PadH    = 16'(PAD_HEIGHT);
  localparam logic [15:0] PadWMax = 16'(PAD_WIDTH - 1);
  localparam logic [15:0] PadHMax = 16'(PAD_HEIGHT - 1);

  logic [15:0] tx;
  logic [15:0] ty;
  logic [6:0]  cid;
  logic        press;

  function automatic logic [7:0] trig(input logic signed [7:0] v);
    logic [7:0] r;
    if (v > 8'sd0) begin
      r = {1'b1, v[6:0]};
    end else begin
      r = 8'h00;
    end
    return r;
  endfunction

  always_comb begin
    tx  = (smp_i.touch_x >= PadW) ? PadWMax : smp_i.touch_x;
    ty  = (smp_i.touch_y >= PadH) ? PadHMax : smp_i.touch_y;
    // A new contact starts when a finger lands after a report without one.
    cid = (smp_i.touch_active && !st_i.was_touching) ? 7'(st_i.cid + 7'd1) : st_i.cid;
    press = smp_i.button_bits[9] | smp_i.touch_click;

    st_o.frame        = 6'(st_i.frame + 6'd1);
    st_o.rtime        = 16'(st_i.rtime + ghrp_pkg::TimeStep);
    st_o.ttime        = 8'(st_i.ttime + 8'd1);
    st_o.cid          = cid;
    st_o.was_touching = smp_i.touch_active;

    rep_o.stick_x   = smp_i.axis_x ^ 8'h80;
    rep_o.stick_y   = smp_i.axis_y ^ 8'h80;
    rep_o.stick_z   = smp_i.axis_z ^ 8'h80;
    rep_o.stick_rz  = smp_i.axis_rz ^ 8'h80;
    rep_o.hat_btn   = {1'b0, smp_i.button_bits[1:0], 1'b0,
                       ghrp_pkg::hat_nibble(smp_i.hat_code)};
    rep_o.btn_mid   = {2'b00, smp_i.button_bits[7:2]};
    rep_o.frame_btn = {st_i.frame, press, smp_i.button_bits[8]};
    rep_o.trig_l    = trig(smp_i.trigger_left);
    rep_o.trig_r    = trig(smp_i.trigger_right);
    rep_o.rtime     = st_o.rtime;
    rep_o.ttime     = st_i.ttime;
    if (smp_i.touch_active) begin
      rep_o.pt_id = {1'b0, cid};
      rep_o.pt_b1 = tx[7:0];
      rep_o.pt_b2 = {ty[3:0], tx[11:8]};
      rep_o.pt_b3 = ty[11:4];
    end else begin
      rep_o.pt_id = ghrp_pkg::PointOff | {1'b0, cid};
      rep_o.pt_b1 = 8'h00;
      rep_o.pt_b2 = 8'h00;
      rep_o.pt_b3 = 8'h00;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gamepad_hid_report_packer.sv =====
// Top level of the gamepad input report packer: sample register, report register, byte sender.
`default_nettype none
// Each accepted sample becomes one 63-byte controller input report, sent as 63 output
// transactions carrying the byte position, the byte value and a last flag on byte 62.
// A sample is held in an input register; once the report register is free, the report
// bytes that depend on it are built by short logic and captured in that register, and the
// running counters (frame counter, 16-bit timestamp advancing by 188, touch timestamp,
// contact id) advance at that moment. The sender then presents one byte per cycle from
// the report register while the sink is ready, so that byte output port sets the sustained
// sample rate. A second sample is taken into the input register while a report is
// still being sent, and its report starts in the cycle right after the last byte of
// the previous one is taken. Touch coordinates are clamped to PAD_WIDTH - 1 and
// PAD_HEIGHT - 1 (each from 1 to 4096). There is no configuration and no clearing pass.
module gamepad_hid_report_packer #(
  parameter int unsigned PAD_WIDTH  = 1920,
  parameter int unsigned PAD_HEIGHT = 943
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  ghrp_sample_if.sink      sample_i,
  ghrp_byte_if.source      byte_o
);

  ghrp_pkg::sample_t sample_q;
  logic              sample_valid_q;
  logic              sample_valid_d;
  ghrp_pkg::rep_t    rep_q;
  ghrp_pkg::rep_t    rep_d;
  logic              rep_valid_q;
  logic              rep_valid_d;
  logic [5:0]        idx_q;
  logic [5:0]        idx_d;
  ghrp_pkg::state_t  st_q;
  ghrp_pkg::state_t  st_d;

  logic in_fire;
  logic out_fire;
  logic at_last;
  logic rep_free;
  logic load_rep;
  logic [7:0] byte_val;

  ghrp_build #(
    .PAD_WIDTH  (PAD_WIDTH),
    .PAD_HEIGHT (PAD_HEIGHT)
  ) u_build (
    .smp_i (sample_q),
    .st_i  (st_q),
    .rep_o (rep_d),
    .st_o  (st_d)
  );

  // The report register frees up when it is empty or its last byte leaves now.
  assign at_last  = (idx_q == ghrp_pkg::LastIndex);
  assign out_fire = byte_o.valid & byte_o.ready;
  assign rep_free = ~rep_valid_q | (out_fire & at_last);
  assign load_rep = sample_valid_q & rep_free;

  assign sample_i.ready = ~sample_valid_q | rep_free;
  assign in_fire        = sample_i.valid & sample_i.ready;

  always_comb begin
    sample_valid_d = sample_valid_q;
    if (in_fire) begin
      sample_valid_d = 1'b1;
    end else if (load_rep) begin
      sample_valid_d = 1'b0;
    end

    rep_valid_d = rep_valid_q;
    idx_d       = idx_q;
    if (load_rep) begin
      rep_valid_d = 1'b1;
      idx_d       = '0;
    end else if (out_fire) begin
      if (at_last) begin
        rep_valid_d = 1'b0;
      end else begin
        idx_d = 6'(idx_q + 6'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_valid_q <= 1'b0;
      rep_valid_q    <= 1'b0;
      idx_q          <= '0;
      st_q           <= '0;
    end else begin
      sample_valid_q <= sample_valid_d;
      rep_valid_q    <= rep_valid_d;
      idx_q          <= idx_d;
      if (load_rep) begin
        st_q <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= sample_i.payload;
    end
    if (load_rep) begin
      rep_q <= rep_d;
    end
  end

  // Byte selection by position; positions not listed are zero.
  always_comb begin
    case (idx_q)
      ghrp_pkg::IdxStickX:   byte_val = rep_q.stick_x;
      ghrp_pkg::IdxStickY:   byte_val = rep_q.stick_y;
      ghrp_pkg::IdxStickZ:   byte_val = rep_q.stick_z;
      ghrp_pkg::IdxStickRz:  byte_val = rep_q.stick_rz;
      ghrp_pkg::IdxHatBtn:   byte_val = rep_q.hat_btn;
      ghrp_pkg::IdxBtnMid:   byte_val = rep_q.btn_mid;
      ghrp_pkg::IdxFrameBtn: byte_val = rep_q.frame_btn;
      ghrp_pkg::IdxTrigL:    byte_val = rep_q.trig_l;
      ghrp_pkg::IdxTrigR:    byte_val = rep_q.trig_r;
      ghrp_pkg::IdxTimeLo:   byte_val = rep_q.rtime[7:0];
      ghrp_pkg::IdxTimeHi:   byte_val = rep_q.rtime[15:8];
      ghrp_pkg::IdxFillA:    byte_val = ghrp_pkg::FillerByte;
      ghrp_pkg::IdxFillB:    byte_val = ghrp_pkg::FillerByte;
      ghrp_pkg::IdxPktCount: byte_val = 8'd1;
      ghrp_pkg::IdxTtime:    byte_val = rep_q.ttime;
      ghrp_pkg::IdxPtId:     byte_val = rep_q.pt_id;
      ghrp_pkg::IdxPtB1:     byte_val = rep_q.pt_b1;
      ghrp_pkg::IdxPtB2:     byte_val = rep_q.pt_b2;
      ghrp_pkg::IdxPtB3:     byte_val = rep_q.pt_b3;
      ghrp_pkg::IdxPt2Id:    byte_val = ghrp_pkg::PointOff | 8'd1;
      default:               byte_val = 8'h00;
    endcase
  end

  assign byte_o.valid               = rep_valid_q;
  assign byte_o.payload.byte_index  = idx_q;
  assign byte_o.payload.report_byte = byte_val;
  assign byte_o.payload.last_byte   = at_last;

  // The byte position never runs past the final byte.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_valid_q |-> (idx_q <= ghrp_pkg::LastIndex))
    else $error("byte position beyond report end");

  // A taken byte that is not the last one is followed by the next position.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !at_last) |=> (rep_valid_q && idx_q == $past(idx_q) + 6'd1))
    else $error("report byte skipped or repeated");

  // A new report always starts at byte zero.
  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rep |=> (rep_valid_q && idx_q == '0))
    else $error("report did not start at byte zero");

  // With no sample waiting, the sender goes idle after the last byte.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && at_last && !sample_valid_q) |=> !rep_valid_q)
    else $error("report sent without a sample");

endmodule
`default_nettype wire
